@@ design/drbt_pkg.sv @@
// ----------------------------------------------------------------------------
// drbt_pkg: shared types and constants for the DRAM row buffer memory
// Holds the command and phase codes, the input and result word layouts,
// the configuration register indexes and their reset values.
// ----------------------------------------------------------------------------
package drbt_pkg;

    // Command codes carried in the input word.
    typedef enum logic [1:0] {
        CMD_POLL  = 2'd0,
        CMD_START = 2'd1,
        CMD_IMMED = 2'd2,
        CMD_CLEAR = 2'd3
    } t_cmd;

    // Phase of the pending timed access.
    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_READ  = 2'd1,
        PH_WRITE = 2'd2
    } t_phase;

    // Control sequencer of the top level.
    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_EXEC  = 2'd2
    } t_state;

    // Configuration register indexes.
    localparam logic [1:0] CFG_HIT_LAT   = 2'd0;
    localparam logic [1:0] CFG_MISS_LAT  = 2'd1;
    localparam logic [1:0] CFG_COL_WIDTH = 2'd2;
    localparam logic [1:0] CFG_ROW_WIDTH = 2'd3;

    localparam int unsigned CFG_DATA_W = 8;

    // Configuration reset values.
    localparam logic [7:0] HIT_LAT_RST   = 8'd2;
    localparam logic [7:0] MISS_LAT_RST  = 8'd10;
    localparam logic [3:0] COL_WIDTH_RST = 4'd6;
    localparam logic [4:0] ROW_WIDTH_RST = 5'd10;

    typedef struct packed {
        t_cmd        command;
        logic        write_op;
        logic [15:0] address;
        logic [31:0] write_data;
    } t_in_word;

    typedef struct packed {
        logic        accepted;
        logic        done_res;
        logic [31:0] read_data;
        logic [7:0]  access_latency;
        logic        row_hit;
        logic        row_conflict;
        logic        busy_res;
        logic [31:0] read_count;
        logic [31:0] write_count;
        logic [31:0] hit_count;
        logic [31:0] miss_count;
        logic [31:0] conflict_count;
    } t_out_word;

endpackage

@@ design/dram_row_buffer_timed_memory_top.sv @@
// ----------------------------------------------------------------------------
// dram_row_buffer_timed_memory_top: word memory with open-page row timing
// Executes poll, timed start, immediate access and statistics-clear
// commands against a word store, tracking open rows per bank and counting
// reads, writes, hits, misses and conflicts.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Signals                          Handshake
// command   in         i_in (t_in_word)                 start high while busy low
// result    out        o_out (t_out_word)               o_strobe, one cycle, no stall
// config    in         i_cfg_we, i_cfg_idx, i_cfg_wdata write when i_cfg_we is high
//
// For every command, in the cycle it is accepted the store is read, and in
// the following cycle the bank table, counters and store are updated. The
// result word appears on o_out with o_strobe for one cycle after that, and
// a new command may be accepted in that same cycle. Busy stays high while
// a command executes, so a command is taken only once the last one is
// through the read-modify-write step that the store's registered read feeds.
// After reset the store is swept to zero, all 2**ADDR_BITS entries (65536 at the
// default), while busy stays high; configuration writes are taken meanwhile.
// The receiver cannot stall, so results are never held back.
// ----------------------------------------------------------------------------
module dram_row_buffer_timed_memory_top #(
    parameter int ADDR_BITS  = 16,
    parameter int BANK_SEL_W = 2
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 start,
    output logic                                 busy,
    input  drbt_pkg::t_in_word                   i_in,
    output logic                                 o_strobe,
    output drbt_pkg::t_out_word                  o_out,
    input  logic                                 i_cfg_we,
    input  logic [1:0]                           i_cfg_idx,
    input  logic [drbt_pkg::CFG_DATA_W-1:0]      i_cfg_wdata
);

    localparam int BANK_COUNT = 1 << BANK_SEL_W;

    // Configuration registers.
    logic [7:0] r_hit_lat;
    logic [7:0] r_miss_lat;
    logic [3:0] r_col_width;
    logic [4:0] r_row_width;

    // Sequencer and the command being executed.
    drbt_pkg::t_state   r_state;
    drbt_pkg::t_state   n_state;
    drbt_pkg::t_in_word r_item;

    // Pending timed access.
    drbt_pkg::t_phase r_phase;
    drbt_pkg::t_phase n_phase;
    logic [7:0]       r_cycles;
    logic [7:0]       n_cycles;
    logic [15:0]      r_held_addr;
    logic [15:0]      n_held_addr;
    logic [31:0]      r_held_data;
    logic [31:0]      n_held_data;

    // Bank table: open flag and open row per bank.
    logic [BANK_COUNT-1:0] r_bank_open;
    logic [BANK_COUNT-1:0] n_bank_open;
    logic [15:0]           r_bank_row [BANK_COUNT];

    // Statistics counters.
    logic [31:0] r_rd_cnt;
    logic [31:0] n_rd_cnt;
    logic [31:0] r_wr_cnt;
    logic [31:0] n_wr_cnt;
    logic [31:0] r_hit_cnt;
    logic [31:0] n_hit_cnt;
    logic [31:0] r_miss_cnt;
    logic [31:0] n_miss_cnt;
    logic [31:0] r_conf_cnt;
    logic [31:0] n_conf_cnt;

    // Result register.
    logic                r_strobe;
    drbt_pkg::t_out_word r_out;
    drbt_pkg::t_out_word n_out;

    // Address decode of the executing command.
    logic [4:0]            bshift;
    logic [5:0]            rshift;
    logic [BANK_SEL_W-1:0] bank;
    logic [15:0]           row_keep;
    logic [15:0]           row;
    logic                  is_hit;
    logic [7:0]            lat;
    logic                  charge;

    // Store interface.
    logic                 accept;
    logic                 st_ready;
    logic                 st_rd_en;
    logic [ADDR_BITS-1:0] st_rd_addr;
    logic [31:0]          st_rd_data;
    logic                 st_wr_en;
    logic [ADDR_BITS-1:0] st_wr_addr;
    logic [31:0]          st_wr_data;

    assign accept = start && !busy;
    assign busy   = (r_state != drbt_pkg::ST_IDLE);

    // Configuration writes are taken at any time.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_lat   <= drbt_pkg::HIT_LAT_RST;
            r_miss_lat  <= drbt_pkg::MISS_LAT_RST;
            r_col_width <= drbt_pkg::COL_WIDTH_RST;
            r_row_width <= drbt_pkg::ROW_WIDTH_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                drbt_pkg::CFG_HIT_LAT:   r_hit_lat   <= i_cfg_wdata;
                drbt_pkg::CFG_MISS_LAT:  r_miss_lat  <= i_cfg_wdata;
                drbt_pkg::CFG_COL_WIDTH: r_col_width <= i_cfg_wdata[3:0];
                drbt_pkg::CFG_ROW_WIDTH: r_row_width <= i_cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    // The store is read in the accept cycle: a poll reads the held address,
    // every other command reads its own address.
    assign st_rd_en   = accept;
    assign st_rd_addr = (i_in.command == drbt_pkg::CMD_POLL) ?
                        ADDR_BITS'(r_held_addr) : ADDR_BITS'(i_in.address);

    drbt_store #(
        .ADDR_BITS (ADDR_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (st_rd_en),
        .i_rd_addr (st_rd_addr),
        .o_rd_data (st_rd_data),
        .i_wr_en   (st_wr_en),
        .i_wr_addr (st_wr_addr),
        .i_wr_data (st_wr_data),
        .o_ready   (st_ready)
    );

    // Split the address into bank and row fields. The column field sits
    // above the two byte-offset bits; shifts past the address give zero.
    assign bshift   = 5'd2 + 5'(r_col_width);
    assign rshift   = 6'(bshift) + 6'(BANK_SEL_W);
    assign bank     = BANK_SEL_W'(r_item.address >> bshift);
    assign row_keep = (r_row_width >= 5'd16) ? 16'hFFFF :
                      16'((17'd1 << r_row_width) - 17'd1);
    assign row      = (r_item.address >> rshift) & row_keep;
    assign is_hit   = r_bank_open[bank] && (r_bank_row[bank] == row);
    assign lat      = is_hit ? r_hit_lat : r_miss_lat;

    // Sequencer: wait for the sweep, then alternate between waiting for a
    // command and executing it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= drbt_pkg::ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            drbt_pkg::ST_CLEAR: begin
                if (st_ready) begin
                    n_state = drbt_pkg::ST_IDLE;
                end
            end
            drbt_pkg::ST_IDLE: begin
                if (start) begin
                    n_state = drbt_pkg::ST_EXEC;
                end
            end
            drbt_pkg::ST_EXEC: begin
                n_state = drbt_pkg::ST_IDLE;
            end
            default: n_state = drbt_pkg::ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_item <= '0;
        end else if (accept) begin
            r_item <= i_in;
        end
    end

    // Execute step: decide the command's effect on the pending access, the
    // bank table, the counters and the store, and build the result word.
    always_comb begin
        n_phase     = r_phase;
        n_cycles    = r_cycles;
        n_held_addr = r_held_addr;
        n_held_data = r_held_data;
        n_bank_open = r_bank_open;
        n_rd_cnt    = r_rd_cnt;
        n_wr_cnt    = r_wr_cnt;
        n_hit_cnt   = r_hit_cnt;
        n_miss_cnt  = r_miss_cnt;
        n_conf_cnt  = r_conf_cnt;
        n_out       = '0;
        charge      = 1'b0;
        st_wr_en    = 1'b0;
        st_wr_addr  = ADDR_BITS'(r_held_addr);
        st_wr_data  = r_held_data;

        unique case (r_item.command)
            drbt_pkg::CMD_POLL: begin
                if (r_phase != drbt_pkg::PH_IDLE) begin
                    n_cycles = (r_cycles != 8'd0) ? r_cycles - 8'd1 : r_cycles;
                    if (n_cycles == 8'd0) begin
                        n_out.done_res = 1'b1;
                        if (r_phase == drbt_pkg::PH_READ) begin
                            n_out.read_data = st_rd_data;
                        end else begin
                            st_wr_en = 1'b1;
                        end
                        n_phase = drbt_pkg::PH_IDLE;
                    end
                end
            end
            drbt_pkg::CMD_START: begin
                if (r_phase == drbt_pkg::PH_IDLE) begin
                    charge         = 1'b1;
                    n_held_addr    = r_item.address;
                    n_held_data    = r_item.write_data;
                    n_phase        = r_item.write_op ? drbt_pkg::PH_WRITE :
                                                       drbt_pkg::PH_READ;
                    n_cycles       = lat;
                    n_out.accepted = 1'b1;
                end
            end
            drbt_pkg::CMD_IMMED: begin
                charge         = 1'b1;
                n_out.done_res = 1'b1;
                st_wr_addr     = ADDR_BITS'(r_item.address);
                st_wr_data     = r_item.write_data;
                if (r_item.write_op) begin
                    st_wr_en = 1'b1;
                end else begin
                    n_out.read_data = st_rd_data;
                end
            end
            drbt_pkg::CMD_CLEAR: begin
                n_rd_cnt    = '0;
                n_wr_cnt    = '0;
                n_hit_cnt   = '0;
                n_miss_cnt  = '0;
                n_conf_cnt  = '0;
                n_bank_open = '0;
                n_phase     = drbt_pkg::PH_IDLE;
                n_cycles    = 8'd0;
            end
            default: ;
        endcase

        // Charging an access: count it and classify it against the bank.
        if (charge) begin
            if (r_item.write_op) begin
                n_wr_cnt = r_wr_cnt + 32'd1;
            end else begin
                n_rd_cnt = r_rd_cnt + 32'd1;
            end
            if (is_hit) begin
                n_hit_cnt = r_hit_cnt + 32'd1;
            end else begin
                n_miss_cnt = r_miss_cnt + 32'd1;
                if (r_bank_open[bank]) begin
                    n_conf_cnt = r_conf_cnt + 32'd1;
                end
                n_bank_open[bank] = 1'b1;
            end
            n_out.access_latency = lat;
            n_out.row_hit        = is_hit;
            n_out.row_conflict   = !is_hit && r_bank_open[bank];
        end

        if (r_state != drbt_pkg::ST_EXEC) begin
            st_wr_en = 1'b0;
        end

        n_out.busy_res       = (n_phase != drbt_pkg::PH_IDLE);
        n_out.read_count     = n_rd_cnt;
        n_out.write_count    = n_wr_cnt;
        n_out.hit_count      = n_hit_cnt;
        n_out.miss_count     = n_miss_cnt;
        n_out.conflict_count = n_conf_cnt;
    end

    // State update, committed only in the execute cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= drbt_pkg::PH_IDLE;
            r_cycles    <= 8'd0;
            r_held_addr <= '0;
            r_held_data <= '0;
            r_bank_open <= '0;
            r_rd_cnt    <= '0;
            r_wr_cnt    <= '0;
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_conf_cnt  <= '0;
        end else if (r_state == drbt_pkg::ST_EXEC) begin
            r_phase     <= n_phase;
            r_cycles    <= n_cycles;
            r_held_addr <= n_held_addr;
            r_held_data <= n_held_data;
            r_bank_open <= n_bank_open;
            r_rd_cnt    <= n_rd_cnt;
            r_wr_cnt    <= n_wr_cnt;
            r_hit_cnt   <= n_hit_cnt;
            r_miss_cnt  <= n_miss_cnt;
            r_conf_cnt  <= n_conf_cnt;
        end
    end

    // The open row is only meaningful while the bank's flag is set, so it
    // is written on every miss and never cleared.
    always_ff @(posedge i_clk) begin
        if ((r_state == drbt_pkg::ST_EXEC) && charge && !is_hit) begin
            r_bank_row[bank] <= row;
        end
    end

    // Result register: one strobe per executed command.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= (r_state == drbt_pkg::ST_EXEC);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == drbt_pkg::ST_EXEC) begin
            r_out <= n_out;
        end
    end

    assign o_strobe = r_strobe;
    assign o_out    = r_out;

`ifndef NO_ASSERTIONS
    // Every accepted command yields its result word via the execute state and result register.
    a_accept_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |-> ##2 o_strobe)
        else $error("accepted command produced no result");

    // The store is never written while its clearing sweep runs.
    a_no_write_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        st_wr_en |-> st_ready)
        else $error("store written during clearing sweep");

    // A result never both starts and completes an access.
    a_accept_xor_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_out.accepted && o_out.done_res))
        else $error("result both accepted and done");

    // A charged access is never both a hit and a conflict.
    a_hit_xor_conflict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !(o_out.row_hit && o_out.row_conflict))
        else $error("row hit and conflict together");
`endif

endmodule

@@ design/drbt_store.sv @@
// ----------------------------------------------------------------------------
// drbt_store: word store with a clearing sweep
// Single-port-write, single-read synchronous memory with registered read
// data. After reset it writes zero to every entry, one per cycle, and
// raises o_ready when the sweep is finished.
// ----------------------------------------------------------------------------
module drbt_store #(
    parameter int ADDR_BITS = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_rd_en,
    input  logic [ADDR_BITS-1:0] i_rd_addr,
    output logic [31:0]          o_rd_data,
    input  logic                 i_wr_en,
    input  logic [ADDR_BITS-1:0] i_wr_addr,
    input  logic [31:0]          i_wr_data,
    output logic                 o_ready
);

    localparam int DEPTH = 1 << ADDR_BITS;

    logic [31:0]          r_mem [DEPTH];
    logic [31:0]          r_rd_data;
    logic                 r_sweep_on;
    logic [ADDR_BITS-1:0] r_sweep_idx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep_on  <= 1'b1;
            r_sweep_idx <= '0;
        end else if (r_sweep_on) begin
            r_sweep_idx <= r_sweep_idx + 1'b1;
            if (&r_sweep_idx) begin
                r_sweep_on <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep_on) begin
            r_mem[r_sweep_idx] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_ready   = !r_sweep_on;

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the DRAM row buffer timed memory
// Drives command words through the start/busy handshake, predicts every
// result word with a behavioral copy of the row buffer, the word store and
// the counters, and compares each strobed result field by field. A short
// directed table runs first, then random phases under several settings.
// ----------------------------------------------------------------------------
module tb_top;
    import drbt_pkg::*;

    localparam int BANKS      = 4;
    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 200;

    // One row of the directed table. Where typed is set, want holds a result
    // word written out by hand; otherwise the predictor supplies it.
    typedef struct {
        t_in_word  cmd;
        bit        typed;
        t_out_word want;
    } t_dir_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    t_in_word              i_in;
    logic                  o_strobe;
    t_out_word             o_out;
    logic                  i_cfg_we;
    logic [1:0]            i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    dram_row_buffer_timed_memory_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_in        (i_in),
        .o_strobe    (o_strobe),
        .o_out       (o_out),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor state: its own copy of the store, the bank table, the
    // pending timed access, the counters and the configuration.
    // ------------------------------------------------------------------
    logic [31:0] mem_words [logic [15:0]];
    bit          bank_open [BANKS];
    logic [15:0] bank_row  [BANKS];
    t_phase      pend_phase;
    logic [7:0]  pend_left;
    logic [15:0] pend_addr;
    logic [31:0] pend_data;
    logic [31:0] cnt_read, cnt_write, cnt_hit, cnt_miss, cnt_clash;
    logic [7:0]  lat_hit, lat_miss;
    logic [3:0]  col_width;
    logic [4:0]  row_width;

    t_out_word   status_due [$];
    int          mismatches = 0;
    logic [15:0] addr_pool [8];
    t_dir_row    dir_tab [$];

    function automatic void reset_model();
        mem_words.delete();
        for (int b = 0; b < BANKS; b++) begin
            bank_open[b] = 1'b0;
            bank_row[b]  = '0;
        end
        pend_phase = PH_IDLE;
        pend_left  = '0;
        pend_addr  = '0;
        pend_data  = '0;
        cnt_read   = '0;
        cnt_write  = '0;
        cnt_hit    = '0;
        cnt_miss   = '0;
        cnt_clash  = '0;
        lat_hit    = HIT_LAT_RST;
        lat_miss   = MISS_LAT_RST;
        col_width  = COL_WIDTH_RST;
        row_width  = ROW_WIDTH_RST;
    endfunction

    // Words never written read back as zero.
    function automatic logic [31:0] word_at(logic [15:0] a);
        return mem_words.exists(a) ? mem_words[a] : 32'd0;
    endfunction

    // Splits the address into bank and row, updates the bank table and
    // the counters, and returns the latency the access is charged.
    function automatic void charge_bank(input logic [15:0] addr, input bit wr,
                                        output logic [7:0] lat, output bit hit,
                                        output bit clash);
        longint unsigned a;
        int unsigned     bsh;
        int unsigned     bank;
        logic [15:0]     row;
        a    = 64'(addr);
        bsh  = 2 + col_width;
        bank = 32'((a >> bsh) & (BANKS - 1));
        // Field widths that reach past the address simply pick up zeros.
        row  = 16'((a >> (bsh + 2)) & ((64'd1 << row_width) - 64'd1));
        if (wr) cnt_write++;
        else cnt_read++;
        hit   = 1'b0;
        clash = 1'b0;
        if (bank_open[bank] && bank_row[bank] == row) begin
            cnt_hit++;
            hit = 1'b1;
            lat = lat_hit;
        end else begin
            cnt_miss++;
            if (bank_open[bank]) begin
                cnt_clash++;
                clash = 1'b1;
            end
            bank_open[bank] = 1'b1;
            bank_row[bank]  = row;
            lat = lat_miss;
        end
    endfunction

    // Expected result word for one accepted command word.
    function automatic t_out_word row_buffer_step(t_in_word w);
        t_out_word  r;
        logic [7:0] lat;
        bit         hit, clash;
        r = '0;
        case (w.command)
            CMD_POLL: begin
                // A poll while idle does nothing at all.
                if (pend_phase != PH_IDLE) begin
                    if (pend_left != 0) pend_left = pend_left - 8'd1;
                    if (pend_left == 0) begin
                        if (pend_phase == PH_READ) r.read_data = word_at(pend_addr);
                        else mem_words[pend_addr] = pend_data;
                        pend_phase = PH_IDLE;
                        r.done_res = 1'b1;
                    end
                end
            end
            CMD_START: begin
                // A start while a timed access is pending is refused.
                if (pend_phase == PH_IDLE) begin
                    pend_addr = w.address;
                    pend_data = w.write_data;
                    if (w.write_op) pend_phase = PH_WRITE;
                    else pend_phase = PH_READ;
                    charge_bank(w.address, w.write_op, lat, hit, clash);
                    pend_left        = lat;
                    r.accepted       = 1'b1;
                    r.access_latency = lat;
                    r.row_hit        = hit;
                    r.row_conflict   = clash;
                end
            end
            CMD_IMMED: begin
                // Performed at once, even with a timed access pending.
                charge_bank(w.address, w.write_op, lat, hit, clash);
                if (w.write_op) mem_words[w.address] = w.write_data;
                else r.read_data = word_at(w.address);
                r.done_res       = 1'b1;
                r.access_latency = lat;
                r.row_hit        = hit;
                r.row_conflict   = clash;
            end
            default: begin
                // Clearing statistics also closes every bank and drops a
                // pending access; the open-row numbers themselves are kept.
                cnt_read  = '0;
                cnt_write = '0;
                cnt_hit   = '0;
                cnt_miss  = '0;
                cnt_clash = '0;
                for (int b = 0; b < BANKS; b++) bank_open[b] = 1'b0;
                pend_phase = PH_IDLE;
                pend_left  = '0;
            end
        endcase
        r.busy_res       = (pend_phase != PH_IDLE);
        r.read_count     = cnt_read;
        r.write_count    = cnt_write;
        r.hit_count      = cnt_hit;
        r.miss_count     = cnt_miss;
        r.conflict_count = cnt_clash;
        return r;
    endfunction

    function automatic t_in_word word_of(t_cmd c, bit wr, logic [15:0] a,
                                         logic [31:0] d);
        t_in_word w;
        w.command    = c;
        w.write_op   = wr;
        w.address    = a;
        w.write_data = d;
        return w;
    endfunction

    // Addresses mostly come from a small pool so that rows get reopened and
    // written words get read back; now and then a fresh address replaces one.
    function automatic logic [15:0] pick_addr();
        int          k;
        logic [15:0] a;
        k = $urandom_range(0, 7);
        case ($urandom_range(0, 3))
            0: begin
                a = 16'($urandom);
                addr_pool[k] = a;
            end
            1: a = addr_pool[k] ^ 16'($urandom_range(0, 3));
            default: a = addr_pool[k];
        endcase
        return a;
    endfunction

    // Mostly well-formed traffic: a timed start followed by polls until it
    // completes, with immediate accesses mixed in. Refused starts, idle
    // polls and statistics clears make up the noise.
    function automatic t_in_word next_word();
        t_in_word w;
        int       r;
        w.write_op   = 1'($urandom_range(0, 1));
        w.address    = pick_addr();
        w.write_data = $urandom;
        r = $urandom_range(0, 99);
        if (pend_phase != PH_IDLE)
            w.command = (r < 78) ? CMD_POLL : (r < 90) ? CMD_IMMED :
                        (r < 97) ? CMD_START : CMD_CLEAR;
        else
            w.command = (r < 55) ? CMD_START : (r < 85) ? CMD_IMMED :
                        (r < 96) ? CMD_POLL : CMD_CLEAR;
        return w;
    endfunction

    // ------------------------------------------------------------------
    // Sender side. Start stays high from one word to the next when there
    // is no gap, so it is never dropped and raised in the same step.
    // ------------------------------------------------------------------
    task automatic send_word(t_in_word w, bit typed, t_out_word want);
        t_out_word got;
        start <= 1'b1;
        i_in  <= w;
        do @(posedge i_clk); while (busy);
        // The word was taken at this edge; predict its result now.
        got = row_buffer_step(w);
        if (typed) status_due.push_back(want);
        else status_due.push_back(got);
    endtask

    task automatic maybe_pause();
        if ($urandom_range(0, 3) == 0) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Holds the sender until every predicted result has come back, then
    // lets the block settle before any register write.
    task automatic drain();
        start <= 1'b0;
        while (status_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic cfg_write(logic [1:0] idx, logic [7:0] val);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        case (idx)
            CFG_HIT_LAT:   lat_hit   = val;
            CFG_MISS_LAT:  lat_miss  = val;
            CFG_COL_WIDTH: col_width = val[3:0];
            default:       row_width = val[4:0];
        endcase
    endtask

    task automatic set_timing(logic [7:0] hl, logic [7:0] ml, logic [7:0] cb,
                              logic [7:0] rb);
        cfg_write(CFG_HIT_LAT, hl);
        cfg_write(CFG_MISS_LAT, ml);
        cfg_write(CFG_COL_WIDTH, cb);
        cfg_write(CFG_ROW_WIDTH, rb);
        i_cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side. The receiver cannot stall, so every strobed word is
    // taken at the edge that ends its cycle and matched to the oldest
    // prediction.
    // ------------------------------------------------------------------
    function automatic void check_field(string name, logic [31:0] want,
                                        logic [31:0] got);
        if (got !== want) begin
            $display("%0t %s: expected %h, actual %h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_out_word want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (status_due.size() == 0) begin
                $display("%0t unexpected result word: expected none, actual %h",
                         $time, o_out);
                mismatches++;
            end else begin
                want = status_due.pop_front();
                check_field("accepted", 32'(want.accepted), 32'(o_out.accepted));
                check_field("done_res", 32'(want.done_res), 32'(o_out.done_res));
                check_field("read_data",      want.read_data,      o_out.read_data);
                check_field("access_latency", 32'(want.access_latency),
                            32'(o_out.access_latency));
                check_field("row_hit", 32'(want.row_hit), 32'(o_out.row_hit));
                check_field("row_conflict", 32'(want.row_conflict),
                            32'(o_out.row_conflict));
                check_field("busy_res", 32'(want.busy_res), 32'(o_out.busy_res));
                check_field("read_count",     want.read_count,     o_out.read_count);
                check_field("write_count",    want.write_count,    o_out.write_count);
                check_field("hit_count",      want.hit_count,      o_out.hit_count);
                check_field("miss_count",     want.miss_count,     o_out.miss_count);
                check_field("conflict_count", want.conflict_count, o_out.conflict_count);
            end
        end
    end

    // Directed table, run at the reset settings: the reset hit and miss
    // latencies, six column bits and ten row bits, so the bank sits in
    // address bits 9:8 and the row starts at bit 10.
    task automatic build_table();
        t_out_word none;
        none = '0;
        // Poll while idle.
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b1, none});
        // First access to an empty bank, then the same row again.
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'h0000, 32'h0), 1'b1,
            '{1'b0, 1'b1, 32'd0, 8'd10, 1'b0, 1'b0, 1'b0,
              32'd1, 32'd0, 32'd0, 32'd1, 32'd0}});
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'h0000, 32'h0), 1'b1,
            '{1'b0, 1'b1, 32'd0, 8'd2, 1'b1, 1'b0, 1'b0,
              32'd2, 32'd0, 32'd1, 32'd1, 32'd0}});
        // Top of the address range with an all-ones word.
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b1, 16'hFFFF, 32'hFFFF_FFFF), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'hFFFF, 32'h0), 1'b0, none});
        // Different row in bank 0: a conflict.
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b1, 16'h1000, 32'hA5A5_A5A5), 1'b0, none});
        // Timed read, a refused start and an immediate access while busy.
        dir_tab.push_back('{word_of(CMD_START, 1'b0, 16'h1000, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_START, 1'b1, 16'h0000, 32'h1234_5678), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'hFFFF, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b0, none});
        // Timed write that the clear throws away.
        dir_tab.push_back('{word_of(CMD_START, 1'b1, 16'h2000, 32'h5A5A_5A5A), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_CLEAR, 1'b0, 16'h0000, 32'h0), 1'b1, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b1, none});
        // The lost write reads zero, and the closed bank is a plain miss.
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'h2000, 32'h0), 1'b0, none});
        // Timed write on an open row, polled to completion and read back.
        dir_tab.push_back('{word_of(CMD_START, 1'b1, 16'h2004, 32'hC3C3_C3C3), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_POLL, 1'b0, 16'h0000, 32'h0), 1'b0, none});
        dir_tab.push_back('{word_of(CMD_IMMED, 1'b0, 16'h2004, 32'h0), 1'b0, none});
    endtask

    initial begin
        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_in        <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_idx   <= '0;
        i_cfg_wdata <= '0;
        for (int k = 0; k < 8; k++) addr_pool[k] = 16'($urandom);
        reset_model();
        build_table();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // The block sweeps its store after reset with busy high; the first
        // send simply waits that out.
        foreach (dir_tab[i]) begin
            maybe_pause();
            send_word(dir_tab[i].cmd, dir_tab[i].typed, dir_tab[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            drain();
            // The first phases take the extreme settings: shortest timing
            // with no column bits, zero latency with fields far past the
            // address, the longest latency, and a row field of no bits.
            case (p)
                0: set_timing(8'd1, 8'd1, 8'd0, 8'd1);
                1: set_timing(8'd0, 8'd0, 8'd15, 8'd31);
                2: set_timing(8'd255, 8'd255, 8'd10, 8'd16);
                3: set_timing(8'd1, 8'd255, 8'd0, 8'd0);
                default: set_timing(8'($urandom_range(1, 6)), 8'($urandom_range(1, 16)),
                                    8'($urandom_range(0, 10)), 8'($urandom_range(1, 16)));
            endcase
            for (int k = 0; k < PHASE_WORDS; k++) begin
                // The last phase runs back to back with no gaps.
                if (p < PHASES - 1) maybe_pause();
                send_word(next_word(), 1'b0, '0);
            end
        end

        drain();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run, including the store
    // sweep after reset and the longest latency phase.
    initial begin
        #2000000;
        $display("Mismatches found");
        $finish;
    end

endmodule
